// File: hdl/sal_pkg.sv
package sal_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int WORD_WIDTH_DEF = 32;

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_PREPEND = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_READ    = 3'd3,
    OP_WRITE   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

// File: hdl/shifting_array_list.sv
// An accepted input beat is latched, then executed in the EXEC state once the output
// register is free; its result is registered. No beat is accepted during execution.
// A waiting result stalls execution of the next item but not its accept.
// Prepend and remove shift the entry cells in parallel; append, read and write do not shift.
// Reset clears the entry count, controller state and output valid; entries are not reset.
module shifting_array_list #(
  parameter int DEPTH      = sal_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = sal_pkg::WORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sal_pkg::OPCODE_W-1:0] opcode,
  input  logic [sal_pkg::POS_W-1:0]    position,
  input  logic [sal_pkg::VALUE_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sal_pkg::VALUE_W-1:0]  read_data,
  output logic [sal_pkg::COUNT_W-1:0]  count,
  output logic [sal_pkg::STATUS_W-1:0] status
);
  import sal_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sal_dp #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .opcode    (opcode),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .count     (count),
    .status    (status)
  );

endmodule

// File: hdl/sal_ctrl.sv
module sal_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sal_pkg::stat_t stat,
  output sal_pkg::cmd_t  cmd
);
  import sal_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> state == S_EXEC)
    else $error("accepted beat did not start execution");

  assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && stat.out_busy |=> state == S_EXEC)
    else $error("execution left while output busy");

  assert property (@(posedge clk) disable iff (rst)
    !(cmd.latch && cmd.exec))
    else $error("latch and exec in the same cycle");

endmodule

// File: hdl/sal_dp.sv
module sal_dp #(
  parameter int DEPTH      = sal_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = sal_pkg::WORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sal_pkg::cmd_t                cmd,
  output sal_pkg::stat_t               stat,
  input  logic [sal_pkg::OPCODE_W-1:0] opcode,
  input  logic [sal_pkg::POS_W-1:0]    position,
  input  logic [sal_pkg::VALUE_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sal_pkg::VALUE_W-1:0]  read_data,
  output logic [sal_pkg::COUNT_W-1:0]  count,
  output logic [sal_pkg::STATUS_W-1:0] status
);
  import sal_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  logic [OPCODE_W-1:0]   op;
  logic [POS_W-1:0]      pos;
  logic [WORD_WIDTH-1:0] word;

  logic [WORD_WIDTH-1:0] cells [DEPTH];
  logic [WORD_WIDTH-1:0] cells_next [DEPTH];
  logic [WORD_WIDTH-1:0] up [DEPTH];
  logic [WORD_WIDTH-1:0] down [DEPTH];

  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic                  full;
  logic                  in_range;
  logic [IDX_W-1:0]      idx;
  logic [CMP_W-1:0]      pos_ext;

  logic                  out_valid_next;
  logic [VALUE_W-1:0]    rd_next;
  status_t               st_next;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op   <= opcode;
      pos  <= position;
      word <= WORD_WIDTH'(value);
    end
  end

  assign full     = (cnt == CNT_W'(DEPTH));
  assign pos_ext  = CMP_W'(pos);
  assign in_range = (pos_ext < CMP_W'(cnt));
  assign idx      = pos_ext[IDX_W-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_nbr
    if (i == 0) begin : g_first
      assign up[i] = word;
    end else begin : g_up
      assign up[i] = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign down[i] = cells[i];
    end else begin : g_down
      assign down[i] = cells[i+1];
    end
  end

  always_comb begin
    cells_next = cells;
    cnt_next   = cnt;
    rd_next    = '0;
    st_next    = ST_DONE;
    case (op_t'(op))
      OP_APPEND: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) == cnt) begin
              cells_next[i] = word;
            end
          end
          cnt_next = cnt + 1'b1;
        end
      end
      OP_PREPEND: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          cells_next = up;
          cnt_next   = cnt + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!in_range) begin
          st_next = ST_RANGE;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (IDX_W'(i) >= idx) begin
              cells_next[i] = down[i];
            end
          end
          cnt_next = cnt - 1'b1;
        end
      end
      OP_READ: begin
        if (!in_range) begin
          st_next = ST_RANGE;
        end else begin
          rd_next = VALUE_W'(cells[idx]);
        end
      end
      OP_WRITE: begin
        if (!in_range) begin
          st_next = ST_RANGE;
        end else begin
          cells_next[idx] = word;
        end
      end
      default: begin
        st_next = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cells <= cells_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.exec) begin
      cnt <= cnt_next;
    end
  end

  assign out_valid_next = cmd.exec | (out_valid & ~out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_data <= rd_next;
      count     <= COUNT_W'(cnt_next);
      status    <= st_next;
    end
  end

  assign stat.out_busy = out_valid & ~out_ready;

  assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count past capacity");

  assert property (@(posedge clk) disable iff (rst)
    cmd.exec && st_next == ST_FULL |-> full)
    else $error("full status on a store with room");

  assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !stat.out_busy)
    else $error("result overwritten before it was taken");

  assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> cnt == $past(cnt))
    else $error("count moved without an operation");

endmodule
